FILE: design/bit_vector_with_range_find_core_macros.svh
// Assertion macros for the bit vector find core checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef BIT_VECTOR_WITH_RANGE_FIND_CORE_MACROS_SVH
`define BIT_VECTOR_WITH_RANGE_FIND_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BVRF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BVRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bvrf_pkg.sv
// Shared constants and codes for the bit vector find core.
// No dependencies; every module in the design imports this package.
`timescale 1ns / 1ps

package bvrf_pkg;

  localparam int MAX_BITS_DEF    = 4096;
  localparam int WORD_BITS_DEF   = 64;
  localparam int POS_W           = 12;
  localparam int CNT_W           = 13;
  localparam int OP_W            = 2;
  localparam int ST_W            = 2;
  localparam int BIT_COUNT_RESET = 4096;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND  = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

endpackage

FILE: design/bvrf_pos_split.sv
// Splits a bit position into word index, offset within the word and word base.
// Depends on bvrf_pkg for the position width.
`timescale 1ns / 1ps

module bvrf_pos_split #(
  parameter int WORD_BITS = 64,
  parameter int AW        = 6,
  parameter int OW        = 6
) (
  input  logic [bvrf_pkg::POS_W-1:0] pos,
  output logic [AW-1:0]              word_idx,
  output logic [OW-1:0]              bit_ofs,
  output logic [bvrf_pkg::POS_W-1:0] word_base
);
  import bvrf_pkg::*;

  // Division by the word size as a multiply by a rounded-up reciprocal.
  // With 12-bit positions and words of at most 64 bits the quotient is exact.
  localparam int SHIFT = 20;
  localparam int RECIP = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int PW    = POS_W + RW;

  logic [PW-1:0]    prod;
  logic [POS_W-1:0] quot;
  logic [POS_W-1:0] rem;

  assign prod      = PW'(pos) * PW'(RECIP);
  assign quot      = POS_W'(prod >> SHIFT);
  assign word_base = POS_W'(quot * POS_W'(WORD_BITS));
  assign rem       = pos - word_base;
  assign bit_ofs   = OW'(rem);
  assign word_idx  = AW'(quot);

endmodule

FILE: design/bvrf_word_scan.sv
// Finds the lowest offset in one word, between two offsets, whose bit matches.
// Offset 0 is the most significant bit of the word. Uses bvrf_pkg by convention.
`timescale 1ns / 1ps

module bvrf_word_scan #(
  parameter int WORD_BITS = 64,
  parameter int OW        = 6
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic                 bit_value,
  input  logic [OW-1:0]        lo_ofs,
  input  logic [OW-1:0]        hi_ofs,
  output logic                 hit,
  output logic [OW-1:0]        hit_ofs
);
  import bvrf_pkg::*;

  logic [WORD_BITS-1:0] keep;

  always_comb begin
    for (int o = 0; o < WORD_BITS; o++) begin
      keep[o] = (OW'(o) >= lo_ofs) && (OW'(o) <= hi_ofs) &&
                (word[WORD_BITS-1-o] == bit_value);
    end
  end

  // Priority encoder: the lowest matching offset wins.
  always_comb begin
    hit_ofs = '0;
    for (int o = WORD_BITS - 1; o >= 0; o--) begin
      if (keep[o]) begin
        hit_ofs = OW'(o);
      end
    end
  end

  assign hit = |keep;

endmodule

FILE: design/bit_vector_with_range_find_core.sv
// Top level of the bit vector core with read, write and range find.
// Depends on bvrf_pkg, bvrf_pos_split and bvrf_word_scan.
`timescale 1ns / 1ps
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low. The
//   operation reads one bit, writes one bit, or finds the lowest position in
//   [in_position, in_last_position] whose bit equals in_bit_value.
//   Every transaction gives one result, shown for exactly one cycle with
//   out_valid high; the receiver cannot stall it.
//   Read and write transactions issue a memory read as they are taken; they and
//   rejected ones then pass the access state, which checks, updates and writes
//   back the word and registers the result. The next transaction may be taken
//   in the cycle that shows the result. A find reads the range word by word up
//   to the first hit or the last word; the word memory delivers one word per
//   cycle through its single read port. bit_count is written through cfg_wr_en /
//   cfg_wr_data, by the user only while idle; the core does not enforce it.
//   After reset the word memory is cleared one word per cycle; busy stays high
//   during that pass while configuration writes are still taken.
//
module bit_vector_with_range_find_core #(
  parameter int MAX_BITS  = bvrf_pkg::MAX_BITS_DEF,
  parameter int WORD_BITS = bvrf_pkg::WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [bvrf_pkg::OP_W-1:0]  in_operation,
  input  logic [bvrf_pkg::POS_W-1:0] in_position,
  input  logic [bvrf_pkg::POS_W-1:0] in_last_position,
  input  logic                       in_bit_value,
  output logic                       out_valid,
  output logic [bvrf_pkg::ST_W-1:0]  out_status,
  output logic                       out_read_bit,
  output logic [bvrf_pkg::POS_W-1:0] out_found_position,
  input  logic                       cfg_wr_en,
  input  logic [bvrf_pkg::CNT_W-1:0] cfg_wr_data
);
  import bvrf_pkg::*;

  localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int OW         = $clog2(WORD_BITS);
  localparam int MB_W       = $clog2(MAX_BITS + 1);
  localparam int CMP_W      = (MB_W > CNT_W) ? MB_W : CNT_W;
  localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_BITS);
  localparam logic [AW-1:0]    LAST_W   = AW'(WORD_COUNT - 1);
  localparam logic [OW-1:0]    TOP_OFS  = OW'(WORD_BITS - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_ACCESS, S_SCAN} state_t;

  state_t               state_r;
  logic [AW-1:0]        clr_addr_r;
  logic [CNT_W-1:0]     bit_count_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic                 out_read_bit_r;
  logic [POS_W-1:0]     out_found_position_r;

  logic [OP_W-1:0]      op_r;
  logic                 val_r;
  logic                 ok_r;
  logic                 first_r;
  logic [AW-1:0]        chk_w_r;
  logic [AW-1:0]        end_w_r;
  logic [OW-1:0]        lo_ofs_r;
  logic [OW-1:0]        hi_ofs_r;
  logic [POS_W-1:0]     base_r;

  logic [WORD_BITS-1:0] bit_words_r [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data_r;

  logic [CMP_W-1:0]     cnt_ext;
  logic [CMP_W-1:0]     cnt_eff;
  logic                 pos_ok;
  logic                 last_ok;
  logic                 order_ok;
  logic                 item_ok;
  logic                 accept;

  logic [AW-1:0]        start_w;
  logic [OW-1:0]        start_ofs;
  logic [POS_W-1:0]     start_base;
  logic [AW-1:0]        last_w;
  logic [OW-1:0]        last_ofs;
  logic [POS_W-1:0]     last_base;

  logic                 at_end;
  logic [OW-1:0]        scan_lo;
  logic [OW-1:0]        scan_hi;
  logic                 scan_hit;
  logic [OW-1:0]        scan_ofs;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [OW-1:0]        bit_sel;
  logic [WORD_BITS-1:0] mod_word;

  bvrf_pos_split #(.WORD_BITS(WORD_BITS), .AW(AW), .OW(OW)) u_split_first (
    .pos       (in_position),
    .word_idx  (start_w),
    .bit_ofs   (start_ofs),
    .word_base (start_base)
  );

  bvrf_pos_split #(.WORD_BITS(WORD_BITS), .AW(AW), .OW(OW)) u_split_last (
    .pos       (in_last_position),
    .word_idx  (last_w),
    .bit_ofs   (last_ofs),
    .word_base (last_base)
  );

  bvrf_word_scan #(.WORD_BITS(WORD_BITS), .OW(OW)) u_scan (
    .word      (rd_data_r),
    .bit_value (val_r),
    .lo_ofs    (scan_lo),
    .hi_ofs    (scan_hi),
    .hit       (scan_hit),
    .hit_ofs   (scan_ofs)
  );

  // Argument checks against the bit count, capped at the capacity.
  assign cnt_ext  = CMP_W'(bit_count_r);
  assign cnt_eff  = (cnt_ext > MAX_CMP) ? MAX_CMP : cnt_ext;
  assign pos_ok   = CMP_W'(in_position) < cnt_eff;
  assign last_ok  = CMP_W'(in_last_position) < cnt_eff;
  assign order_ok = in_last_position >= in_position;
  assign accept   = start && (state_r == S_IDLE);

  always_comb begin
    case (in_operation)
      OP_READ:  item_ok = pos_ok;
      OP_WRITE: item_ok = pos_ok;
      OP_FIND:  item_ok = pos_ok && last_ok && order_ok;
      default:  item_ok = 1'b0;
    endcase
  end

  // Only the first and last words of a range are masked at the edges.
  assign at_end  = (chk_w_r == end_w_r);
  assign scan_lo = first_r ? lo_ofs_r : '0;
  assign scan_hi = at_end ? hi_ofs_r : TOP_OFS;

  // The next word is fetched while the current one is checked.
  assign rd_en   = (accept && item_ok) ||
                   ((state_r == S_SCAN) && !scan_hit && !at_end);
  assign rd_addr = (state_r == S_SCAN) ? (chk_w_r + 1'b1) : start_w;

  assign bit_sel = TOP_OFS - lo_ofs_r;
  always_comb begin
    mod_word          = rd_data_r;
    mod_word[bit_sel] = val_r;
  end

  assign wr_en   = (state_r == S_CLEAR) ||
                   ((state_r == S_ACCESS) && ok_r && (op_r == OP_WRITE));
  assign wr_addr = (state_r == S_CLEAR) ? clr_addr_r : chk_w_r;
  assign wr_data = (state_r == S_CLEAR) ? '0 : mod_word;

  // Word memory: one write port, one read port with registered data.
  // A write in the access cycle lands before any later read is issued.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bit_words_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= bit_words_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      bit_count_r <= CNT_W'(BIT_COUNT_RESET);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr_en) begin
        bit_count_r <= cfg_wr_data;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == LAST_W) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_r     <= in_operation;
            val_r    <= in_bit_value;
            ok_r     <= item_ok;
            first_r  <= 1'b1;
            chk_w_r  <= start_w;
            end_w_r  <= last_w;
            lo_ofs_r <= start_ofs;
            hi_ofs_r <= last_ofs;
            base_r   <= start_base;
            if (item_ok && (in_operation == OP_FIND)) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_ACCESS;
            end
          end
        end
        S_ACCESS: begin
          out_valid_r          <= 1'b1;
          out_status_r         <= ok_r ? ST_OK : ST_INVALID;
          out_read_bit_r       <= ok_r && (op_r == OP_READ) && rd_data_r[bit_sel];
          out_found_position_r <= '0;
          state_r              <= S_IDLE;
        end
        S_SCAN: begin
          if (scan_hit) begin
            out_valid_r          <= 1'b1;
            out_status_r         <= ST_OK;
            out_read_bit_r       <= 1'b0;
            out_found_position_r <= base_r + POS_W'(scan_ofs);
            state_r              <= S_IDLE;
          end else if (at_end) begin
            out_valid_r          <= 1'b1;
            out_status_r         <= ST_NOT_FOUND;
            out_read_bit_r       <= 1'b0;
            out_found_position_r <= '0;
            state_r              <= S_IDLE;
          end else begin
            first_r <= 1'b0;
            chk_w_r <= chk_w_r + 1'b1;
            base_r  <= base_r + POS_W'(WORD_BITS);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_bit       = out_read_bit_r;
  assign out_found_position = out_found_position_r;

endmodule

FILE: design/bvrf_checker.sv
// Port-level checks for the bit vector find core, bound to the top level.
// Depends on bvrf_pkg and bit_vector_with_range_find_core_macros.svh.
`timescale 1ns / 1ps
`include "bit_vector_with_range_find_core_macros.svh"

module bvrf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [bvrf_pkg::ST_W-1:0]  out_status,
  input logic                       out_read_bit,
  input logic [bvrf_pkg::POS_W-1:0] out_found_position
);
  import bvrf_pkg::*;

  // Every accepted transaction makes the core busy in the cycle after it is taken.
  `BVRF_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "core not busy after a transaction")

  // A result appears only as the core returns to idle.
  `BVRF_ASSERT_SAME(a_result_when_idle, out_valid, !busy, "result shown while busy")
  `BVRF_ASSERT_SAME(a_result_after_work, out_valid, $past(busy), "result without prior work")

  // A failed transaction carries no bit and no position.
  `BVRF_ASSERT_SAME(a_fail_fields_zero, out_valid && (out_status != ST_OK), (out_found_position == '0) && !out_read_bit, "nonzero fields on a failed transaction")

endmodule

bind bit_vector_with_range_find_core bvrf_checker u_bvrf_checker (.*);
